### hw/rtl/gct_pkg.sv
// gct_pkg: widths, token class codes and character helpers for the g-code tokenizer
`timescale 1ns / 1ps

package gct_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ClassW = 4;

  // token class codes
  localparam logic [ClassW-1:0] ClsDefault  = 4'd0;
  localparam logic [ClassW-1:0] ClsComment  = 4'd1;
  localparam logic [ClassW-1:0] ClsNumber   = 4'd2;
  localparam logic [ClassW-1:0] ClsWord     = 4'd3;
  localparam logic [ClassW-1:0] ClsParam    = 4'd4;
  localparam logic [ClassW-1:0] ClsString   = 4'd5;
  localparam logic [ClassW-1:0] ClsOperator = 4'd6;
  localparam logic [ClassW-1:0] ClsBuf      = 4'd7;
  localparam logic [ClassW-1:0] ClsCmd      = 4'd8;
  localparam logic [ClassW-1:0] ClsMsg      = 4'd9;

  // register indexes
  localparam logic [0:0] RegStartStyle = 1'b0;

  typedef logic [CharW-1:0] char_t;
  typedef logic [ClassW-1:0] class_t;

  // ascii upper case to lower case, everything else unchanged
  function automatic char_t low_case(input char_t c);
    char_t r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  // bytes that carry on a number, word or param run
  function automatic logic is_cont(input char_t c);
    return is_digit(c) || c == "." || c == "-" || c == "+" || c == "e" || c == "E";
  endfunction

  function automatic logic is_word_start(input char_t c);
    char_t l;
    l = low_case(c);
    return l == "g" || l == "m" || l == "t" || l == "n";
  endfunction

  function automatic logic is_param_start(input char_t c);
    char_t l;
    l = low_case(c);
    return l == "x" || l == "y" || l == "z" || l == "a" || l == "b" || l == "c" ||
           l == "u" || l == "v" || l == "d" || l == "h" || l == "s" || l == "f" ||
           l == "p" || l == "i" || l == "j" || l == "k";
  endfunction

  function automatic logic is_oper(input char_t c);
    return c == "*" || c == "/" || c == "-" || c == "+";
  endfunction

  // case-insensitive match of a five-byte window against "(xyz,"
  function automatic logic tag_match(input char_t w0, input char_t w1, input char_t w2,
                                     input char_t w3, input char_t w4,
                                     input char_t t1, input char_t t2, input char_t t3);
    return w0 == "(" && low_case(w1) == t1 && low_case(w2) == t2 &&
           low_case(w3) == t3 && w4 == ",";
  endfunction

endpackage

### hw/rtl/gct_in_if.sv
// gct_in_if: input channel carrying one text byte and its lookahead window per word
`timescale 1ns / 1ps

interface gct_in_if import gct_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t cur_char;
  char_t ahead_one;
  char_t ahead_two;
  char_t ahead_three;
  char_t ahead_four;
  logic  first_char;
  logic  last_char;

  modport source (
    output valid, cur_char, ahead_one, ahead_two, ahead_three, ahead_four,
           first_char, last_char,
    input  ready
  );

  modport sink (
    input  valid, cur_char, ahead_one, ahead_two, ahead_three, ahead_four,
           first_char, last_char,
    output ready
  );
endinterface

### hw/rtl/gct_out_if.sv
// gct_out_if: result channel carrying one token class per word
`timescale 1ns / 1ps

interface gct_out_if import gct_pkg::*; ();
  logic   valid;
  logic   ready;
  class_t style;
  logic   run_end;

  modport source (
    output valid, style, run_end,
    input  ready
  );

  modport sink (
    input  valid, style, run_end,
    output ready
  );
endinterface

### hw/rtl/gcode_char_tokenizer.sv
// gcode_char_tokenizer: streaming token classifier for g-code text
`timescale 1ns / 1ps

// Takes one text byte per cycle while the result is not stalled, with its
// four-byte lookahead, and returns its token class (default, comment,
// number, word, param, string, operator, buf, cmd, msg) in the same order.
// A word is held in an input register; the class update logic between that
// register and the result register also feeds the held class back, so one
// byte is classified per clock when not stalled. A stalled result holds the
// pipeline, while a free input register still takes a new word. start_style
// at address 0 is the class loaded for a byte flagged first_char; values
// above 9 are treated as default. Write it only while no word is in flight.
module gcode_char_tokenizer import gct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  // streams
  gct_in_if.sink      in_i,
  gct_out_if.source   out_o
);

  // configuration register
  class_t start_style_q;
  logic   cfg_sel;
  logic   cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_sel  = (paddr_i[2] == RegStartStyle) && (paddr_i[1:0] == 2'b00);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && cfg_sel;
  assign prdata_o = cfg_sel ? {{(32-ClassW){1'b0}}, start_style_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_style_q <= ClsDefault;
    end else if (cfg_wr) begin
      start_style_q <= pwdata_i[ClassW-1:0];
    end
  end

  // input register
  logic  s1_valid_q;
  char_t c0_q, c1_q, c2_q, c3_q, c4_q;
  logic  first_q, last_q;
  logic  advance;
  logic  in_fire;

  assign advance    = !out_o.valid || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      c0_q    <= in_i.cur_char;
      c1_q    <= in_i.ahead_one;
      c2_q    <= in_i.ahead_two;
      c3_q    <= in_i.ahead_three;
      c4_q    <= in_i.ahead_four;
      first_q <= in_i.first_char;
      last_q  <= in_i.last_char;
    end
  end

  // class update
  class_t cur_class_q, cur_class_d;
  class_t shown;
  class_t s_in;
  class_t s_run;
  logic   closed;

  always_comb begin
    s_in = first_q ? start_style_q : cur_class_q;
    if (s_in > ClsMsg) begin
      s_in = ClsDefault;
    end

    s_run  = s_in;
    closed = 1'b0;
    unique case (s_in)
      ClsOperator: begin
        if (!is_oper(c0_q)) s_run = ClsDefault;
      end
      ClsNumber, ClsWord, ClsParam: begin
        if (!is_cont(c0_q)) s_run = ClsDefault;
      end
      ClsComment, ClsBuf, ClsCmd, ClsMsg: begin
        if (c0_q == ")") closed = 1'b1;
      end
      default: begin
      end
    endcase

    shown = s_run;
    // look for the start of a new run
    if (!closed && s_run == ClsDefault) begin
      priority if (tag_match(c0_q, c1_q, c2_q, c3_q, c4_q, "b", "u", "f")) begin
        shown = ClsBuf;
      end else if (tag_match(c0_q, c1_q, c2_q, c3_q, c4_q, "c", "m", "d")) begin
        shown = ClsCmd;
      end else if (tag_match(c0_q, c1_q, c2_q, c3_q, c4_q, "m", "s", "g")) begin
        shown = ClsMsg;
      end else if (c0_q == "(") begin
        shown = ClsComment;
      end else if (is_digit(c0_q) || (c0_q == "." && is_digit(c1_q))) begin
        shown = ClsNumber;
      end else if (is_word_start(c0_q)) begin
        shown = ClsWord;
      end else if (is_param_start(c0_q)) begin
        shown = ClsParam;
      end else if (c0_q == "\"") begin
        shown = ClsString;
      end else if (is_oper(c0_q)) begin
        shown = ClsOperator;
      end else begin
        shown = ClsDefault;
      end
    end

    cur_class_d = closed ? ClsDefault : shown;
  end

  // held class and result register
  logic   out_valid_q;
  class_t out_style_q;
  logic   out_run_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_class_q <= ClsDefault;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        cur_class_q <= cur_class_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_style_q   <= shown;
      out_run_end_q <= last_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.style   = out_style_q;
  assign out_o.run_end = out_run_end_q;

endmodule
